// ===== hw/rtl/i2cbrs_pkg.sv =====
// Package for the I2C bus recovery supervisor: beat payload types, the
// function codes, configuration register indexes and reset values.
// No dependencies.
`default_nettype none

package i2cbrs_pkg;

   typedef enum logic [1:0] {
      FUNC_NOTE      = 2'd0,
      FUNC_SERVICE   = 2'd1,
      FUNC_SET_READY = 2'd2
   } func_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FAILURE_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_RETRY_INTERVAL    = 2'd1;
   localparam logic [1:0] CSR_LOG_INTERVAL      = 2'd2;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   // Reset values of the configuration registers.
   localparam logic [7:0]  FAILURE_THRESHOLD_RESET = 8'd3;
   localparam logic [15:0] RETRY_INTERVAL_RESET    = 16'd2000;
   localparam logic [31:0] LOG_INTERVAL_RESET      = 32'd10000;

   localparam logic [7:0]  FAIL_COUNT_MAX = 8'd255;
   localparam logic [31:0] GENERATION_RESET = 32'd1;

   typedef struct packed {
      logic [7:0]  failure_threshold;
      logic [15:0] retry_interval_ms;
      logic [31:0] log_interval_ms;
   } cfg_type;

   typedef struct packed {
      func_type    func;
      logic        success;
      logic [7:0]  fault_code;
      logic [31:0] now_ms;
      logic        ready_value;
      logic        recover_ok;
   } req_type;

   typedef struct packed {
      logic        bus_ready;
      logic        io_allowed;
      logic        recovery_armed;
      logic        attempted;
      logic        recovered;
      logic        log_failure;
      logic [7:0]  failure_count;
      logic [7:0]  last_error;
      logic [31:0] generation;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/i2cbrs_if.sv =====
// Channel interfaces of the I2C bus recovery supervisor: the request
// channel and the response channel, each with valid/ready and its payload.
// No dependencies.
`default_nettype none

interface i2cbrs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic        success;
   logic [7:0]  fault_code;
   logic [31:0] now_ms;
   logic        ready_value;
   logic        recover_ok;

   modport source (
      output valid, func, success, fault_code, now_ms, ready_value, recover_ok,
      input  ready
   );
   modport sink (
      input  valid, func, success, fault_code, now_ms, ready_value, recover_ok,
      output ready
   );
endinterface

interface i2cbrs_rsp_if;
   logic        valid;
   logic        ready;
   logic        bus_ready;
   logic        io_allowed;
   logic        recovery_armed;
   logic        attempted;
   logic        recovered;
   logic        log_failure;
   logic [7:0]  failure_count;
   logic [7:0]  last_error;
   logic [31:0] generation;

   modport source (
      output valid, bus_ready, io_allowed, recovery_armed, attempted, recovered,
             log_failure, failure_count, last_error, generation,
      input  ready
   );
   modport sink (
      input  valid, bus_ready, io_allowed, recovery_armed, attempted, recovered,
             log_failure, failure_count, last_error, generation,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/i2cbrs_in_stage.sv =====
// Input register of the I2C bus recovery supervisor: captures one request
// beat and holds it until the engine takes it. Depends on i2cbrs_pkg and
// the request interface.
`default_nettype none

module i2cbrs_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   i2cbrs_req_if.sink            req_if,
   input  logic                  advance,
   output logic                  stage_valid,
   output i2cbrs_pkg::req_type   stage_req
);
   import i2cbrs_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;
   logic    take;

   // The register may refill in the same cycle in which its beat moves on.
   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff.func        <= func_type'(req_if.func);
         req_ff.success     <= req_if.success;
         req_ff.fault_code  <= req_if.fault_code;
         req_ff.now_ms      <= req_if.now_ms;
         req_ff.ready_value <= req_if.ready_value;
         req_ff.recover_ok  <= req_if.recover_ok;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_req   = req_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/i2cbrs_engine.sv =====
// Supervisor state and its single-pass update for one request beat.
// Produces the response fields from the updated state. Depends on i2cbrs_pkg.
`default_nettype none

module i2cbrs_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  i2cbrs_pkg::req_type   req,
   input  i2cbrs_pkg::cfg_type   cfg,
   output i2cbrs_pkg::rsp_type   rsp
);
   import i2cbrs_pkg::*;

   logic        ready_ff,        ready_in;
   logic        pending_ff,      pending_in;
   logic [7:0]  fail_count_ff,   fail_count_in;
   logic [7:0]  error_ff,        error_in;
   logic [31:0] next_attempt_ff, next_attempt_in;
   logic [31:0] last_log_ff,     last_log_in;
   logic        log_valid_ff,    log_valid_in;
   logic [31:0] gen_ff,          gen_in;

   logic        attempted;
   logic        recovered;
   logic        log_flag;
   logic [7:0]  fail_inc;
   logic [31:0] due_delta;
   logic        due_reached;
   logic [31:0] log_delta;
   logic        log_due;

   assign fail_inc    = (fail_count_ff == FAIL_COUNT_MAX) ? fail_count_ff
                                                           : fail_count_ff + 8'd1;
   // The due time counts as reached while the wrapped distance is not negative.
   assign due_delta   = req.now_ms - next_attempt_ff;
   assign due_reached = !due_delta[31];
   assign log_delta   = req.now_ms - last_log_ff;
   assign log_due     = !log_valid_ff || (log_delta >= cfg.log_interval_ms);

   always_comb begin
      ready_in        = ready_ff;
      pending_in      = pending_ff;
      fail_count_in   = fail_count_ff;
      error_in        = error_ff;
      next_attempt_in = next_attempt_ff;
      last_log_in     = last_log_ff;
      log_valid_in    = log_valid_ff;
      gen_in          = gen_ff;
      attempted       = 1'b0;
      recovered       = 1'b0;
      log_flag        = 1'b0;
      unique case (req.func)
         FUNC_NOTE: begin
            if (req.success) begin
               fail_count_in = 8'd0;
               error_in      = 8'd0;
            end else begin
               error_in      = req.fault_code;
               fail_count_in = fail_inc;
               if (fail_inc >= cfg.failure_threshold && !pending_ff) begin
                  pending_in      = 1'b1;
                  next_attempt_in = req.now_ms;
               end
            end
         end
         FUNC_SERVICE: begin
            if (pending_ff && due_reached) begin
               attempted = 1'b1;
               if (req.recover_ok) begin
                  recovered     = 1'b1;
                  ready_in      = 1'b1;
                  pending_in    = 1'b0;
                  fail_count_in = 8'd0;
                  error_in      = 8'd0;
                  gen_in        = gen_ff + 32'd1;
               end else begin
                  ready_in        = 1'b0;
                  next_attempt_in = req.now_ms + {16'd0, cfg.retry_interval_ms};
                  if (log_due) begin
                     log_flag     = 1'b1;
                     last_log_in  = req.now_ms;
                     log_valid_in = 1'b1;
                  end
               end
            end
         end
         FUNC_SET_READY: begin
            ready_in = req.ready_value;
            if (req.ready_value) begin
               pending_in    = 1'b0;
               fail_count_in = 8'd0;
               error_in      = 8'd0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff        <= 1'b0;
         pending_ff      <= 1'b0;
         fail_count_ff   <= 8'd0;
         error_ff        <= 8'd0;
         next_attempt_ff <= 32'd0;
         last_log_ff     <= 32'd0;
         log_valid_ff    <= 1'b0;
         gen_ff          <= GENERATION_RESET;
      end else if (fire) begin
         ready_ff        <= ready_in;
         pending_ff      <= pending_in;
         fail_count_ff   <= fail_count_in;
         error_ff        <= error_in;
         next_attempt_ff <= next_attempt_in;
         last_log_ff     <= last_log_in;
         log_valid_ff    <= log_valid_in;
         gen_ff          <= gen_in;
      end
   end

   always_comb begin
      rsp.bus_ready      = ready_in;
      rsp.io_allowed     = ready_in && !pending_in;
      rsp.recovery_armed = pending_in;
      rsp.attempted      = attempted;
      rsp.recovered      = recovered;
      rsp.log_failure    = log_flag;
      rsp.failure_count  = fail_count_in;
      rsp.last_error     = error_in;
      rsp.generation     = gen_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_bus_recovery_supervisor.sv =====
// I2C bus recovery supervisor, top level: configuration registers, input
// register, supervisor engine and response register. Depends on i2cbrs_pkg,
// the channel interfaces, i2cbrs_in_stage and i2cbrs_engine.
//
// The block takes one request beat per clock cycle while the sink takes the
// responses, and returns exactly one response beat for each, in order. The
// engine updates the supervisor state from the beat in the input register in
// a single combinational pass (a saturating count, two 32-bit wrapping subtracts
// for the due time and log spacing, and two 32-bit adds), and the response
// register holds the result and presents it until the sink takes it.
// The response register separates the two sides: a new request is still
// taken while a finished response waits for the sink, and the pipeline only
// stops when both registers are full. Function code 3 changes nothing and
// returns the current status. The configuration registers are written through
// the csr_ port and must only be written while no beat is in flight; a write
// to an index beyond the register list is ignored.
`default_nettype none

module i2c_bus_recovery_supervisor (
   input  logic                                     clock,
   input  logic                                     reset,
   i2cbrs_req_if.sink                               req_if,
   i2cbrs_rsp_if.source                             rsp_if,
   input  logic                                     csr_wr_en,
   input  logic [i2cbrs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [i2cbrs_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import i2cbrs_pkg::*;

   // Configuration registers.
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.failure_threshold <= FAILURE_THRESHOLD_RESET;
         cfg_ff.retry_interval_ms <= RETRY_INTERVAL_RESET;
         cfg_ff.log_interval_ms   <= LOG_INTERVAL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FAILURE_THRESHOLD: cfg_ff.failure_threshold <= csr_wdata[7:0];
            CSR_RETRY_INTERVAL:    cfg_ff.retry_interval_ms <= csr_wdata[15:0];
            CSR_LOG_INTERVAL:      cfg_ff.log_interval_ms   <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline control: the beat in the input register moves on whenever the
   // response register is empty or is being emptied in this cycle.
   logic    stage_valid;
   req_type stage_req;
   logic    advance;
   logic    fire;
   rsp_type rsp_next;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;

   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign fire    = stage_valid && advance;

   i2cbrs_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_req   (stage_req)
   );

   i2cbrs_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (stage_req),
      .cfg   (cfg_ff),
      .rsp   (rsp_next)
   );

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.bus_ready      = rsp_ff.bus_ready;
   assign rsp_if.io_allowed     = rsp_ff.io_allowed;
   assign rsp_if.recovery_armed = rsp_ff.recovery_armed;
   assign rsp_if.attempted      = rsp_ff.attempted;
   assign rsp_if.recovered      = rsp_ff.recovered;
   assign rsp_if.log_failure    = rsp_ff.log_failure;
   assign rsp_if.failure_count  = rsp_ff.failure_count;
   assign rsp_if.last_error     = rsp_ff.last_error;
   assign rsp_if.generation     = rsp_ff.generation;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the I2C bus recovery supervisor.
// Depends on i2cbrs_pkg, the channel interfaces and the supervisor top level.

module tb;
   import i2cbrs_pkg::*;

   // The function code that the block must treat as a no-op, and the one
   // configuration index that lies beyond the register list.
   localparam logic [1:0] FUNC_UNUSED      = 2'd3;
   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;

   localparam int PHASES          = 8;
   localparam int BEATS_PER_PHASE = 210;
   localparam int SATURATION_RUN  = 270;
   localparam int HOLD_CYCLES     = 300;

   // One row of the directed table: the request beat and, where it can be
   // stated outright, the response that it must produce.
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } row_type;

   logic clock;
   logic reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   i2cbrs_req_if req_ch ();
   i2cbrs_rsp_if rsp_ch ();

   i2c_bus_recovery_supervisor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Our own copy of the supervisor state and its configuration. These move
   // only when a request beat is accepted or a register is written.
   cfg_type     cfg;
   logic        link_ready;
   logic        recovery_pending;
   logic [7:0]  fail_run;
   logic [7:0]  held_error;
   logic [31:0] due_ms;
   logic [31:0] last_log_ms;
   logic        log_seen;
   logic [31:0] recoveries;

   // Responses still owed by the block, oldest first.
   rsp_type awaited_status[$];
   row_type plan[$];
   cfg_type settings[PHASES];

   int          errors;
   int          tx_idle_pct;
   int          rx_idle_pct;
   bit          rx_hold;
   logic [31:0] clock_ms;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // A generous ceiling on the whole run; a correct run ends well before it.
   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Works out the response to one accepted request and moves the state on.
   // The due-time test is a wrapping compare: the attempt is due once the
   // distance from the due time, taken modulo 2^32, has its top bit clear.
   function automatic rsp_type supervise(input req_type r);
      rsp_type     o;
      logic [31:0] lag;
      logic [31:0] since;
      o = '0;
      lag = r.now_ms - due_ms;
      since = r.now_ms - last_log_ms;
      case (r.func)
         FUNC_NOTE: begin
            if (r.success) begin
               fail_run = '0;
               held_error = '0;
            end else begin
               held_error = r.fault_code;
               if (fail_run != FAIL_COUNT_MAX) fail_run = fail_run + 8'd1;
               // A further failure while a recovery waits leaves its due time alone.
               if (fail_run >= cfg.failure_threshold && !recovery_pending) begin
                  recovery_pending = 1'b1;
                  due_ms = r.now_ms;
               end
            end
         end
         FUNC_SERVICE: begin
            if (recovery_pending && !lag[31]) begin
               o.attempted = 1'b1;
               link_ready = 1'b0;
               if (r.recover_ok) begin
                  o.recovered = 1'b1;
                  link_ready = 1'b1;
                  recovery_pending = 1'b0;
                  fail_run = '0;
                  held_error = '0;
                  recoveries = recoveries + 32'd1;
               end else begin
                  due_ms = r.now_ms + 32'(cfg.retry_interval_ms);
                  // The first failed attempt always logs; later ones only once
                  // the log interval has passed since the last flag.
                  if (!log_seen || since >= cfg.log_interval_ms) begin
                     o.log_failure = 1'b1;
                     last_log_ms = r.now_ms;
                     log_seen = 1'b1;
                  end
               end
            end
         end
         FUNC_SET_READY: begin
            link_ready = r.ready_value;
            if (r.ready_value) begin
               recovery_pending = 1'b0;
               fail_run = '0;
               held_error = '0;
            end
         end
         default: ;
      endcase
      o.bus_ready      = link_ready;
      o.io_allowed     = link_ready && !recovery_pending;
      o.recovery_armed = recovery_pending;
      o.failure_count  = fail_run;
      o.last_error     = held_error;
      o.generation     = recoveries;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Beat construction
   // ------------------------------------------------------------------

   function automatic req_type beat(input logic [1:0] op, input logic succ,
                                    input logic [7:0] code, input logic [31:0] now,
                                    input logic rv, input logic rok);
      req_type r;
      r.func        = func_type'(op);
      r.success     = succ;
      r.fault_code  = code;
      r.now_ms      = now;
      r.ready_value = rv;
      r.recover_ok  = rok;
      return r;
   endfunction

   // A response with no attempt made on it, for the directed rows.
   function automatic rsp_type quiet_status(input logic rdy, input logic io,
                                            input logic armed, input logic [7:0] cnt,
                                            input logic [7:0] err, input logic [31:0] gen);
      rsp_type o;
      o = '0;
      o.bus_ready      = rdy;
      o.io_allowed     = io;
      o.recovery_armed = armed;
      o.failure_count  = cnt;
      o.last_error     = err;
      o.generation     = gen;
      return o;
   endfunction

   // Moves the millisecond clock on. Mostly small steps, so that retries and
   // log spacing come into play, with the odd long jump, the odd jump to
   // anywhere in the 32-bit range, and now and then a step backwards.
   function automatic logic [31:0] tick_ms();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70)      clock_ms = clock_ms + $urandom_range(0, 1500);
      else if (pick < 92) clock_ms = clock_ms + $urandom_range(0, 40000);
      else if (pick < 97) clock_ms = $urandom;
      else                clock_ms = clock_ms - $urandom_range(0, 3000);
      return clock_ms;
   endfunction

   // A random beat of ordinary traffic. Failures outweigh successes so that
   // recoveries are armed often; fields that the operation ignores still
   // carry random values.
   function automatic req_type traffic_beat();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(99);
      r = beat(FUNC_NOTE, 1'($urandom_range(1)), 8'($urandom_range(255)), tick_ms(),
               1'($urandom_range(1)), 1'($urandom_range(1)));
      if (pick < 45) begin
         r.success = ($urandom_range(99) < 20);
      end else if (pick < 85) begin
         r.func = FUNC_SERVICE;
         r.recover_ok = ($urandom_range(99) < 40);
      end else if (pick < 96) begin
         r.func = FUNC_SET_READY;
      end else begin
         r.func = func_type'(FUNC_UNUSED);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------

   // Offers one request beat and returns at the edge that accepts it. The
   // expectation is queued at that same edge: typed in for directed rows
   // that state it, otherwise from the predictor.
   task automatic send_beat(input req_type r, input logic typed, input rsp_type want);
      rsp_type p;
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= r.func;
      req_ch.success     <= r.success;
      req_ch.fault_code  <= r.fault_code;
      req_ch.now_ms      <= r.now_ms;
      req_ch.ready_value <= r.ready_value;
      req_ch.recover_ok  <= r.recover_ok;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      p = supervise(r);
      awaited_status.push_back(typed ? want : p);
   endtask

   // Stops offering and waits until every owed response has arrived, so that
   // the block is quite idle.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_FAILURE_THRESHOLD: cfg.failure_threshold = data[7:0];
         CSR_RETRY_INTERVAL:    cfg.retry_interval_ms = data[15:0];
         CSR_LOG_INTERVAL:      cfg.log_interval_ms   = data;
         default: ;
      endcase
   endtask

   // The narrow registers get random junk above their width, which the
   // block must drop.
   task automatic load_settings(input cfg_type c);
      write_reg(CSR_FAILURE_THRESHOLD, {$urandom} & 32'hFFFF_FF00 | 32'(c.failure_threshold));
      write_reg(CSR_RETRY_INTERVAL, {$urandom} & 32'hFFFF_0000 | 32'(c.retry_interval_ms));
      write_reg(CSR_LOG_INTERVAL, c.log_interval_ms);
   endtask

   // ------------------------------------------------------------------
   // Receiving and checking
   // ------------------------------------------------------------------

   // The sink stalls at random; on request it holds off for a long stretch,
   // which fills the block and pushes back on the request side.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold) begin
            rx_hold = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.bus_ready      = rsp_ch.bus_ready;
         got.io_allowed     = rsp_ch.io_allowed;
         got.recovery_armed = rsp_ch.recovery_armed;
         got.attempted      = rsp_ch.attempted;
         got.recovered      = rsp_ch.recovered;
         got.log_failure    = rsp_ch.log_failure;
         got.failure_count  = rsp_ch.failure_count;
         got.last_error     = rsp_ch.last_error;
         got.generation     = rsp_ch.generation;
         if (awaited_status.size() == 0) begin
            $display("%0t: response beat with none expected, actual %0h", $time, got);
            errors++;
         end else begin
            want = awaited_status.pop_front();
            check_field("bus_ready", 32'(want.bus_ready), 32'(got.bus_ready));
            check_field("io_allowed", 32'(want.io_allowed), 32'(got.io_allowed));
            check_field("recovery_armed", 32'(want.recovery_armed),
                        32'(got.recovery_armed));
            check_field("attempted", 32'(want.attempted), 32'(got.attempted));
            check_field("recovered", 32'(want.recovered), 32'(got.recovered));
            check_field("log_failure", 32'(want.log_failure), 32'(got.log_failure));
            check_field("failure_count", 32'(want.failure_count),
                        32'(got.failure_count));
            check_field("last_error", 32'(want.last_error), 32'(got.last_error));
            check_field("generation", want.generation, got.generation);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_FAILURE_THRESHOLD;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= FUNC_NOTE;
      req_ch.success     <= 1'b0;
      req_ch.fault_code  <= '0;
      req_ch.now_ms      <= '0;
      req_ch.ready_value <= 1'b0;
      req_ch.recover_ok  <= 1'b0;

      errors            = 0;
      rx_hold           = 1'b0;
      clock_ms          = '0;
      cfg.failure_threshold = FAILURE_THRESHOLD_RESET;
      cfg.retry_interval_ms = RETRY_INTERVAL_RESET;
      cfg.log_interval_ms   = LOG_INTERVAL_RESET;
      link_ready        = 1'b0;
      recovery_pending  = 1'b0;
      fail_run          = '0;
      held_error        = '0;
      due_ms            = '0;
      last_log_ms       = '0;
      log_seen          = 1'b0;
      recoveries        = GENERATION_RESET;

      // First third of the run: the sender idles now and then, the sink often.
      tx_idle_pct = 29;
      rx_idle_pct = 61;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset configuration (threshold 3, retry
      // 2000 ms, log spacing 10000 ms). A service tick with nothing pending
      // changes nothing; set-ready brings the bus up; failures latch their
      // code, the third arms a recovery due at once.
      plan.push_back(row_type'{beat(FUNC_SERVICE, 1'b0, 8'h00, 32'd0, 1'b0, 1'b1), 1'b1,
                               quiet_status(1'b0, 1'b0, 1'b0, 8'd0, 8'h00, 32'd1)});
      plan.push_back(row_type'{beat(FUNC_SET_READY, 1'b0, 8'h00, 32'd0, 1'b1, 1'b0), 1'b1,
                               quiet_status(1'b1, 1'b1, 1'b0, 8'd0, 8'h00, 32'd1)});
      plan.push_back(row_type'{beat(FUNC_NOTE, 1'b0, 8'hFF, 32'd100, 1'b0, 1'b0), 1'b1,
                               quiet_status(1'b1, 1'b1, 1'b0, 8'd1, 8'hFF, 32'd1)});
      plan.push_back(row_type'{beat(FUNC_NOTE, 1'b0, 8'h00, 32'd200, 1'b0, 1'b0), 1'b1,
                               quiet_status(1'b1, 1'b1, 1'b0, 8'd2, 8'h00, 32'd1)});
      plan.push_back(row_type'{beat(FUNC_NOTE, 1'b1, 8'h5A, 32'd300, 1'b0, 1'b0), 1'b1,
                               quiet_status(1'b1, 1'b1, 1'b0, 8'd0, 8'h00, 32'd1)});
      plan.push_back(row_type'{beat(FUNC_NOTE, 1'b0, 8'hA5, 32'd1000, 1'b0, 1'b0),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_NOTE, 1'b0, 8'hA5, 32'd1001, 1'b0, 1'b0),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_NOTE, 1'b0, 8'hC3, 32'd1002, 1'b0, 1'b0), 1'b1,
                               quiet_status(1'b1, 1'b0, 1'b1, 8'd3, 8'hC3, 32'd1)});
      // With a recovery already waiting, a further failure keeps the due time.
      plan.push_back(row_type'{beat(FUNC_NOTE, 1'b0, 8'h7E, 32'd5000, 1'b0, 1'b0),
                               1'b0, '0});
      // One millisecond short of due, then due: the attempt fails and logs.
      plan.push_back(row_type'{beat(FUNC_SERVICE, 1'b0, 8'h00, 32'd1001, 1'b0, 1'b1),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_SERVICE, 1'b0, 8'h00, 32'd1002, 1'b0, 1'b0),
                               1'b0, '0});
      // Before the retry time nothing happens; at it, a second failure that
      // the rate limit keeps quiet.
      plan.push_back(row_type'{beat(FUNC_SERVICE, 1'b0, 8'h00, 32'd2000, 1'b0, 1'b1),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_SERVICE, 1'b0, 8'h00, 32'd3002, 1'b0, 1'b0),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_NOTE, 1'b1, 8'h00, 32'd3100, 1'b0, 1'b0),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_SERVICE, 1'b0, 8'h00, 32'd5002, 1'b0, 1'b1),
                               1'b0, '0});
      // The unused function code with every field high must change nothing.
      plan.push_back(row_type'{beat(FUNC_UNUSED, 1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_SET_READY, 1'b1, 8'hFF, 32'd6000, 1'b0, 1'b1),
                               1'b0, '0});
      // Arm just before the clock wraps and attempt just after it; the log
      // spacing is also measured across the wrap.
      plan.push_back(row_type'{beat(FUNC_NOTE, 1'b0, 8'h11, 32'hFFFF_FFF0, 1'b0, 1'b0),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_NOTE, 1'b0, 8'h22, 32'hFFFF_FFF1, 1'b0, 1'b0),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_NOTE, 1'b0, 8'h44, 32'hFFFF_FFF2, 1'b0, 1'b0),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_SERVICE, 1'b0, 8'h00, 32'd5, 1'b0, 1'b0),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_SERVICE, 1'b0, 8'h00, 32'd2005, 1'b0, 1'b1),
                               1'b0, '0});
      plan.push_back(row_type'{beat(FUNC_SET_READY, 1'b0, 8'h00, 32'h8000_0000, 1'b1, 1'b0),
                               1'b0, '0});
      foreach (plan[i]) send_beat(plan[i].item, plan[i].typed, plan[i].want);

      // Settings for the random phases: the low extremes, the high extremes
      // (with a run of failures long enough to saturate the count), a zero
      // threshold so that any failure arms, four random middling settings,
      // and finally the reset values again.
      settings[0] = '{8'd1, 16'd0, 32'd0};
      settings[1] = '{8'd255, 16'hFFFF, 32'hFFFF_FFFF};
      settings[2] = '{8'd0, 16'd1, 32'd1};
      for (int k = 3; k < PHASES - 1; k++) begin
         settings[k].failure_threshold = 8'($urandom_range(1, 6));
         settings[k].retry_interval_ms = 16'($urandom_range(0, 4000));
         settings[k].log_interval_ms   = $urandom_range(0, 20000);
      end
      settings[PHASES-1] = '{FAILURE_THRESHOLD_RESET, RETRY_INTERVAL_RESET,
                             LOG_INTERVAL_RESET};

      for (int phase = 0; phase < PHASES; phase++) begin
         // Registers only change with the block empty.
         settle();
         if (phase == 3) begin
            tx_idle_pct = 61;
            rx_idle_pct = 29;
         end
         if (phase == 6) begin
            // Last stretch: no idling on either side, opened by a long
            // hold-off of the sink while the sender keeps offering beats.
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            rx_hold = 1'b1;
         end
         load_settings(settings[phase]);
         if (phase == 0) write_reg(CSR_UNUSED_INDEX, $urandom);
         repeat (BEATS_PER_PHASE) send_beat(traffic_beat(), 1'b0, '0);
         if (phase == 1) begin
            repeat (SATURATION_RUN)
               send_beat(beat(FUNC_NOTE, 1'b0, 8'($urandom_range(255)), tick_ms(),
                              1'($urandom_range(1)), 1'($urandom_range(1))), 1'b0, '0);
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
